// ===== src/dmx_cue_crossfade_editor_macros.svh =====
// Assertion macros shared by the cue editor RTL.
`ifndef DMX_CUE_CROSSFADE_EDITOR_MACROS_SVH
`define DMX_CUE_CROSSFADE_EDITOR_MACROS_SVH

// Concurrent check on the rising clock edge, quiet while reset is high.
`define DCE_ASSERT_RST(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Same-cycle implication built on the check above.
`define DCE_ASSERT_IMPL(name, pre, post, msg) \
   `DCE_ASSERT_RST(name, (pre) |-> (post), msg)

`endif

// ===== src/dce_pkg.sv =====
`timescale 1ns / 1ps
// Constants, widths and codes of the DMX cue crossfade editor.
package dce_pkg;

   localparam int CHANNELS = 512;
   localparam int CUES     = 12;

   localparam int CMD_W    = 4;
   localparam int CH_IN_W  = 9;
   localparam int CUE_W    = 4;
   localparam int LEVEL_W  = 8;
   localparam int STATUS_W = 2;
   localparam int PROG_W   = 7;
   localparam int TICKS_W  = 16;

   localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int CNT_W    = $clog2(CHANNELS + 1);
   localparam int SLOTS    = CUES + 2;
   localparam int SLOT_W   = $clog2(SLOTS);
   localparam int ADDR_W   = SLOT_W + CH_W;
   localparam int DEPTH    = SLOTS << CH_W;
   localparam int PROD_W   = LEVEL_W + TICKS_W;
   localparam int DIV_STEPS = LEVEL_W;
   localparam int DIVC_W   = $clog2(DIV_STEPS);

   typedef logic [CMD_W-1:0]    cmd_type;
   typedef logic [LEVEL_W-1:0]  level_type;
   typedef logic [STATUS_W-1:0] status_type;
   typedef logic [SLOT_W-1:0]   slot_type;

   // slots above the cues hold the live universe and the undo copy
   localparam slot_type SLOT_LIVE = SLOT_W'(CUES);
   localparam slot_type SLOT_UNDO = SLOT_W'(CUES + 1);

   localparam cmd_type CMD_READ     = 4'd0;
   localparam cmd_type CMD_UP16     = 4'd1;
   localparam cmd_type CMD_UP1      = 4'd2;
   localparam cmd_type CMD_DOWN16   = 4'd3;
   localparam cmd_type CMD_DOWN1    = 4'd4;
   localparam cmd_type CMD_TOGGLE   = 4'd5;
   localparam cmd_type CMD_INSERT   = 4'd6;
   localparam cmd_type CMD_DELETE   = 4'd7;
   localparam cmd_type CMD_BLACKOUT = 4'd8;
   localparam cmd_type CMD_FULL     = 4'd9;
   localparam cmd_type CMD_UNDO     = 4'd10;
   localparam cmd_type CMD_SAVE     = 4'd11;
   localparam cmd_type CMD_GOTO     = 4'd12;
   localparam cmd_type CMD_TICK     = 4'd13;

   localparam status_type ST_OK    = 2'd0;
   localparam status_type ST_BUSY  = 2'd1;
   localparam status_type ST_RANGE = 2'd2;

   localparam level_type LEVEL_ZERO   = 8'h00;
   localparam level_type LEVEL_FULL   = 8'hFF;
   localparam level_type LEVEL_STEP   = 8'h10;
   localparam level_type LEVEL_COARSE = 8'hE0;
   localparam level_type LEVEL_HALF   = 8'd128;

   localparam logic [TICKS_W-1:0] TICKS_RESET = 16'd10;
   localparam int PROG_SCALE = 100;
   localparam int PROG_CAP   = 99;

endpackage

// ===== src/dmx_cue_crossfade_editor.sv =====
`timescale 1ns / 1ps
// Cue editor with crossfade: live universe, cue store and undo copy in one RAM.
//
//   channel  direction  handshake             word
//   req_     in         req_valid/req_stall   cmd, channel, cue
//   rsp_     out        rsp_valid/rsp_stall   value, status, fading, progress, active_cue
//   csr_     in         csr_write             fade_ticks
//
// After reset a clearing pass writes zero to all DEPTH RAM words (7168 words at
// 12 cues), then items are taken one at a time. Whole-universe passes (snapshot,
// store, load, restore, fill) walk every channel, a shift pass only part of the
// universe; a nudge runs a snapshot and a one-channel write. A fade tick reads
// both cues and divides their weighted sum with the 8-step divider, one channel
// at a time, on the single RAM. Progress also goes through the divider while
// fading; a stalled result holds the last state.
`include "dmx_cue_crossfade_editor_macros.svh"

module dmx_cue_crossfade_editor (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [dce_pkg::CMD_W-1:0]    req_cmd,
   input  logic [dce_pkg::CH_IN_W-1:0]  req_channel,
   input  logic [dce_pkg::CUE_W-1:0]    req_cue,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [dce_pkg::LEVEL_W-1:0]  rsp_value,
   output logic [dce_pkg::STATUS_W-1:0] rsp_status,
   output logic                         rsp_fading,
   output logic [dce_pkg::PROG_W-1:0]   rsp_progress,
   output logic [dce_pkg::CUE_W-1:0]    rsp_active_cue,
   input  logic                         csr_write,
   input  logic [dce_pkg::TICKS_W-1:0]  csr_wdata
);

   localparam logic [3:0] S_CLEAR  = 4'd0;
   localparam logic [3:0] S_IDLE   = 4'd1;
   localparam logic [3:0] S_DECIDE = 4'd2;
   localparam logic [3:0] S_SETUP  = 4'd3;
   localparam logic [3:0] S_PASS   = 4'd4;
   localparam logic [3:0] S_FA     = 4'd5;
   localparam logic [3:0] S_FB     = 4'd6;
   localparam logic [3:0] S_FC     = 4'd7;
   localparam logic [3:0] S_FDIV   = 4'd8;
   localparam logic [3:0] S_FW     = 4'd9;
   localparam logic [3:0] S_FIN    = 4'd10;
   localparam logic [3:0] S_PROG   = 4'd11;
   localparam logic [3:0] S_PDIV   = 4'd12;
   localparam logic [3:0] S_VALUE  = 4'd13;
   localparam logic [3:0] S_OUT    = 4'd14;

   localparam logic [2:0] PK_SNAP    = 3'd0;
   localparam logic [2:0] PK_POKE    = 3'd1;
   localparam logic [2:0] PK_INSERT  = 3'd2;
   localparam logic [2:0] PK_DELETE  = 3'd3;
   localparam logic [2:0] PK_FILL    = 3'd4;
   localparam logic [2:0] PK_RESTORE = 3'd5;
   localparam logic [2:0] PK_STORE   = 3'd6;
   localparam logic [2:0] PK_LOAD    = 3'd7;

   localparam logic [1:0] OFF_SAME  = 2'd0;
   localparam logic [1:0] OFF_BELOW = 2'd1;
   localparam logic [1:0] OFF_ABOVE = 2'd2;

   typedef struct packed {
      dce_pkg::slot_type          src;
      dce_pkg::slot_type          dst;
      logic                       fill;
      logic                       down;
      logic [1:0]                 off;
      logic [dce_pkg::CH_W-1:0]   start;
      logic [dce_pkg::CNT_W-1:0]  count;
   } pass_desc_type;

   // state RAM: cues, live universe, undo copy
   logic [dce_pkg::LEVEL_W-1:0] levels_mem [dce_pkg::DEPTH];
   logic                        mem_we;
   logic [dce_pkg::ADDR_W-1:0]  mem_waddr;
   logic [dce_pkg::ADDR_W-1:0]  mem_raddr;
   dce_pkg::level_type          mem_wdata;
   dce_pkg::level_type          mem_rdata_ff;

   logic [3:0]                   state_ff, state_in;
   logic [dce_pkg::ADDR_W-1:0]   clr_ff, clr_in;
   logic [dce_pkg::TICKS_W-1:0]  ticks_ff, ticks_in;
   logic                         undo_valid_ff, undo_valid_in;
   logic [dce_pkg::CUE_W-1:0]    cur_ff, cur_in;
   logic [dce_pkg::CUE_W-1:0]    target_ff, target_in;
   logic                         fade_ff, fade_in;
   logic [dce_pkg::TICKS_W-1:0]  elapsed_ff, elapsed_in;
   logic                         rsp_valid_ff, rsp_valid_in;

   dce_pkg::cmd_type             cmd_ff, cmd_in;
   logic [dce_pkg::CH_IN_W-1:0]  ch_ff, ch_in;
   logic [dce_pkg::CUE_W-1:0]    cue_ff, cue_in;
   dce_pkg::status_type          status_ff, status_in;
   dce_pkg::level_type           nv_ff, nv_in;
   logic [2:0]                   pk0_ff, pk0_in, pk1_ff, pk1_in;
   logic                         two_ff, two_in;
   logic                         phase_ff, phase_in;
   logic [dce_pkg::CH_W-1:0]     pos_ff, pos_in, wpos_ff, wpos_in, fpos_ff, fpos_in;
   logic [dce_pkg::CNT_W-1:0]    left_ff, left_in;
   logic                         pend_ff, pend_in;
   logic [dce_pkg::PROD_W-1:0]   aprod_ff, aprod_in, rem_ff, rem_in, dsr_ff, dsr_in;
   dce_pkg::level_type           q_ff, q_in;
   logic [dce_pkg::DIVC_W-1:0]   cnt_ff, cnt_in;
   logic                         cap_ff, cap_in;
   logic [dce_pkg::PROG_W-1:0]   prog_ff, prog_in;
   dce_pkg::level_type           rsp_value_ff, rsp_value_in;
   dce_pkg::status_type          rsp_status_ff, rsp_status_in;
   logic                         rsp_fading_ff, rsp_fading_in;
   logic [dce_pkg::PROG_W-1:0]   rsp_prog_ff, rsp_prog_in;
   logic [dce_pkg::CUE_W-1:0]    rsp_cue_ff, rsp_cue_in;

   pass_desc_type                desc;
   logic [2:0]                   kind;
   logic                         ok_ch;
   logic [dce_pkg::CH_W-1:0]     chi;
   logic [dce_pkg::CH_W-1:0]     src_pos;
   dce_pkg::slot_type            cur_slot, target_slot;
   dce_pkg::level_type           v;
   logic [dce_pkg::TICKS_W-1:0]  e_next;
   logic [dce_pkg::PROD_W-1:0]   prog_num;
   logic                         div_ge;
   logic                         out_free;

   assign ok_ch       = ({1'b0, ch_ff} < (dce_pkg::CH_IN_W + 1)'(dce_pkg::CHANNELS));
   assign chi         = ch_ff[dce_pkg::CH_W-1:0];
   assign cur_slot    = dce_pkg::SLOT_W'(cur_ff);
   assign target_slot = dce_pkg::SLOT_W'(target_ff);
   assign v           = mem_rdata_ff;
   assign e_next      = elapsed_ff + 1'b1;
   assign prog_num    = dce_pkg::PROD_W'(elapsed_ff) * dce_pkg::PROD_W'(dce_pkg::PROG_SCALE);
   assign div_ge      = (rem_ff >= dsr_ff);
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign kind        = phase_ff ? pk1_ff : pk0_ff;

   // pass descriptor for the current phase
   always_comb begin
      desc.src   = dce_pkg::SLOT_LIVE;
      desc.dst   = dce_pkg::SLOT_LIVE;
      desc.fill  = 1'b0;
      desc.down  = 1'b0;
      desc.off   = OFF_SAME;
      desc.start = '0;
      desc.count = dce_pkg::CNT_W'(dce_pkg::CHANNELS);
      unique case (kind)
         PK_SNAP: begin
            desc.dst = dce_pkg::SLOT_UNDO;
         end
         PK_POKE: begin
            desc.fill  = 1'b1;
            desc.start = chi;
            desc.count = dce_pkg::CNT_W'(1);
         end
         PK_INSERT: begin
            desc.down  = 1'b1;
            desc.off   = OFF_BELOW;
            desc.start = dce_pkg::CH_W'(dce_pkg::CHANNELS - 1);
            desc.count = dce_pkg::CNT_W'(dce_pkg::CHANNELS - 1) - dce_pkg::CNT_W'(chi);
         end
         PK_DELETE: begin
            desc.off   = OFF_ABOVE;
            desc.start = chi;
            desc.count = dce_pkg::CNT_W'(dce_pkg::CHANNELS - 1) - dce_pkg::CNT_W'(chi);
         end
         PK_FILL: begin
            desc.fill = 1'b1;
         end
         PK_RESTORE: begin
            desc.src = dce_pkg::SLOT_UNDO;
         end
         PK_STORE: begin
            desc.dst = cur_slot;
         end
         PK_LOAD: begin
            desc.src = cur_slot;
         end
         default: begin
            desc.src = dce_pkg::SLOT_LIVE;
         end
      endcase
   end

   always_comb begin
      unique case (desc.off)
         OFF_BELOW: src_pos = pos_ff - 1'b1;
         OFF_ABOVE: src_pos = pos_ff + 1'b1;
         default:   src_pos = pos_ff;
      endcase
   end

   // RAM ports
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = '0;
      mem_wdata = dce_pkg::LEVEL_ZERO;
      mem_raddr = {dce_pkg::SLOT_LIVE, req_channel[dce_pkg::CH_W-1:0]};
      unique case (state_ff)
         S_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
         end
         S_PASS: begin
            mem_raddr = {desc.src, src_pos};
            if (pend_ff) begin
               mem_we    = 1'b1;
               mem_waddr = {desc.dst, wpos_ff};
               mem_wdata = desc.fill ? nv_ff : mem_rdata_ff;
            end
         end
         S_FA:    mem_raddr = {cur_slot, fpos_ff};
         S_FB:    mem_raddr = {target_slot, fpos_ff};
         S_FW: begin
            mem_we    = 1'b1;
            mem_waddr = {dce_pkg::SLOT_LIVE, fpos_ff};
            mem_wdata = q_ff;
         end
         S_VALUE, S_OUT: mem_raddr = {dce_pkg::SLOT_LIVE, chi};
         default: mem_raddr = {dce_pkg::SLOT_LIVE, req_channel[dce_pkg::CH_W-1:0]};
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         levels_mem[mem_waddr] <= mem_wdata;
      end
      mem_rdata_ff <= levels_mem[mem_raddr];
   end

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      ticks_in      = csr_write ? csr_wdata : ticks_ff;
      undo_valid_in = undo_valid_ff;
      cur_in        = cur_ff;
      target_in     = target_ff;
      fade_in       = fade_ff;
      elapsed_in    = elapsed_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      cmd_in        = cmd_ff;
      ch_in         = ch_ff;
      cue_in        = cue_ff;
      status_in     = status_ff;
      nv_in         = nv_ff;
      pk0_in        = pk0_ff;
      pk1_in        = pk1_ff;
      two_in        = two_ff;
      phase_in      = phase_ff;
      pos_in        = pos_ff;
      wpos_in       = wpos_ff;
      fpos_in       = fpos_ff;
      left_in       = left_ff;
      pend_in       = pend_ff;
      aprod_in      = aprod_ff;
      rem_in        = rem_ff;
      dsr_in        = dsr_ff;
      q_in          = q_ff;
      cnt_in        = cnt_ff;
      cap_in        = cap_ff;
      prog_in       = prog_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      rsp_fading_in = rsp_fading_ff;
      rsp_prog_in   = rsp_prog_ff;
      rsp_cue_in    = rsp_cue_ff;

      unique case (state_ff)
         S_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == dce_pkg::ADDR_W'(dce_pkg::DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd_in   = req_cmd;
               ch_in    = req_channel;
               cue_in   = req_cue;
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            status_in = dce_pkg::ST_OK;
            two_in    = 1'b0;
            phase_in  = 1'b0;
            pk0_in    = PK_SNAP;
            pk1_in    = PK_POKE;
            state_in  = S_FIN;
            if (fade_ff && (cmd_ff != dce_pkg::CMD_TICK)) begin
               status_in = dce_pkg::ST_BUSY;
            end else begin
               unique case (cmd_ff)
                  dce_pkg::CMD_UP16: begin
                     if (ok_ch) begin
                        nv_in = (v < (dce_pkg::LEVEL_FULL - dce_pkg::LEVEL_STEP)) ?
                                v + dce_pkg::LEVEL_STEP : dce_pkg::LEVEL_FULL;
                        two_in = 1'b1;
                        state_in = S_SETUP;
                     end
                  end
                  dce_pkg::CMD_UP1: begin
                     if (ok_ch && (v != dce_pkg::LEVEL_FULL)) begin
                        nv_in = v + 1'b1;
                        two_in = 1'b1;
                        state_in = S_SETUP;
                     end
                  end
                  dce_pkg::CMD_DOWN16: begin
                     if (ok_ch) begin
                        if (v == dce_pkg::LEVEL_FULL) begin
                           nv_in = dce_pkg::LEVEL_COARSE;
                        end else if (v > dce_pkg::LEVEL_STEP) begin
                           nv_in = v - dce_pkg::LEVEL_STEP;
                        end else begin
                           nv_in = dce_pkg::LEVEL_ZERO;
                        end
                        two_in = 1'b1;
                        state_in = S_SETUP;
                     end
                  end
                  dce_pkg::CMD_DOWN1: begin
                     if (ok_ch && (v != dce_pkg::LEVEL_ZERO)) begin
                        nv_in = v - 1'b1;
                        two_in = 1'b1;
                        state_in = S_SETUP;
                     end
                  end
                  dce_pkg::CMD_TOGGLE: begin
                     if (ok_ch) begin
                        nv_in = (v < dce_pkg::LEVEL_HALF) ? dce_pkg::LEVEL_FULL :
                                dce_pkg::LEVEL_ZERO;
                        two_in = 1'b1;
                        state_in = S_SETUP;
                     end
                  end
                  dce_pkg::CMD_INSERT: begin
                     if (ok_ch) begin
                        pk1_in = PK_INSERT;
                        two_in = 1'b1;
                        state_in = S_SETUP;
                     end
                  end
                  dce_pkg::CMD_DELETE: begin
                     if (ok_ch) begin
                        pk1_in = PK_DELETE;
                        two_in = 1'b1;
                        state_in = S_SETUP;
                     end
                  end
                  dce_pkg::CMD_BLACKOUT: begin
                     nv_in = dce_pkg::LEVEL_ZERO;
                     pk1_in = PK_FILL;
                     two_in = 1'b1;
                     state_in = S_SETUP;
                  end
                  dce_pkg::CMD_FULL: begin
                     nv_in = dce_pkg::LEVEL_FULL;
                     pk1_in = PK_FILL;
                     two_in = 1'b1;
                     state_in = S_SETUP;
                  end
                  dce_pkg::CMD_UNDO: begin
                     if (undo_valid_ff) begin
                        undo_valid_in = 1'b0;
                        pk0_in = PK_RESTORE;
                        state_in = S_SETUP;
                     end
                  end
                  dce_pkg::CMD_SAVE: begin
                     pk0_in = PK_STORE;
                     state_in = S_SETUP;
                  end
                  dce_pkg::CMD_GOTO: begin
                     if ({1'b0, cue_ff} >= (dce_pkg::CUE_W + 1)'(dce_pkg::CUES)) begin
                        status_in = dce_pkg::ST_RANGE;
                     end else begin
                        undo_valid_in = 1'b0;
                        pk0_in = PK_STORE;
                        state_in = S_SETUP;
                        if (ticks_ff == '0) begin
                           pk1_in = PK_LOAD;
                           two_in = 1'b1;
                        end else begin
                           target_in  = cue_ff;
                           fade_in    = 1'b1;
                           elapsed_in = '0;
                        end
                     end
                  end
                  dce_pkg::CMD_TICK: begin
                     if (fade_ff) begin
                        if ((e_next >= ticks_ff) || (e_next == '0)) begin
                           // fade over: load the target cue outright
                           cur_in     = target_ff;
                           fade_in    = 1'b0;
                           elapsed_in = '0;
                           pk0_in     = PK_LOAD;
                           state_in   = S_SETUP;
                        end else begin
                           elapsed_in = e_next;
                           fpos_in    = '0;
                           state_in   = S_FA;
                        end
                     end
                  end
                  default: begin
                     state_in = S_FIN;
                  end
               endcase
               // every edit snapshot sets the undo copy valid
               if (two_in && (cmd_ff != dce_pkg::CMD_GOTO)) begin
                  undo_valid_in = 1'b1;
               end
            end
         end
         S_SETUP: begin
            pos_in   = desc.start;
            left_in  = desc.count;
            pend_in  = 1'b0;
            state_in = S_PASS;
         end
         S_PASS: begin
            pend_in = (left_ff != '0);
            wpos_in = pos_ff;
            if (left_ff != '0) begin
               pos_in  = desc.down ? pos_ff - 1'b1 : pos_ff + 1'b1;
               left_in = left_ff - 1'b1;
            end
            if ((left_ff == '0) && !pend_ff) begin
               if (!phase_ff && two_ff) begin
                  phase_in = 1'b1;
                  if (cmd_ff == dce_pkg::CMD_GOTO) begin
                     cur_in = cue_ff;
                  end
                  state_in = S_SETUP;
               end else begin
                  state_in = S_FIN;
               end
            end
         end
         S_FA: begin
            state_in = S_FB;
         end
         S_FB: begin
            aprod_in = dce_pkg::PROD_W'(v) * dce_pkg::PROD_W'(ticks_ff - elapsed_ff);
            state_in = S_FC;
         end
         S_FC: begin
            rem_in   = aprod_ff + dce_pkg::PROD_W'(v) * dce_pkg::PROD_W'(elapsed_ff);
            dsr_in   = dce_pkg::PROD_W'(ticks_ff) << (dce_pkg::DIV_STEPS - 1);
            q_in     = '0;
            cnt_in   = '0;
            state_in = S_FDIV;
         end
         S_FDIV, S_PDIV: begin
            // restoring division, one quotient bit a cycle
            if (div_ge) begin
               rem_in = rem_ff - dsr_ff;
            end
            q_in   = {q_ff[dce_pkg::LEVEL_W-2:0], div_ge};
            dsr_in = dsr_ff >> 1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == dce_pkg::DIVC_W'(dce_pkg::DIV_STEPS - 1)) begin
               state_in = (state_ff == S_FDIV) ? S_FW : S_VALUE;
            end
         end
         S_FW: begin
            fpos_in = fpos_ff + 1'b1;
            if (fpos_ff == dce_pkg::CH_W'(dce_pkg::CHANNELS - 1)) begin
               state_in = S_FIN;
            end else begin
               state_in = S_FA;
            end
         end
         S_FIN: begin
            if (fade_ff) begin
               state_in = S_PROG;
            end else begin
               prog_in  = '0;
               state_in = S_VALUE;
            end
         end
         S_PROG: begin
            rem_in   = prog_num;
            dsr_in   = dce_pkg::PROD_W'(ticks_ff) << (dce_pkg::DIV_STEPS - 1);
            q_in     = '0;
            cnt_in   = '0;
            cap_in   = (ticks_ff == '0) ||
                       (prog_num >= dce_pkg::PROD_W'(ticks_ff) *
                                    dce_pkg::PROD_W'(dce_pkg::PROG_CAP));
            state_in = S_PDIV;
         end
         S_VALUE: begin
            if (fade_ff) begin
               prog_in = cap_ff ? dce_pkg::PROG_W'(dce_pkg::PROG_CAP) :
                                  q_ff[dce_pkg::PROG_W-1:0];
            end
            state_in = S_OUT;
         end
         S_OUT: begin
            // hold until the output register is free
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = ok_ch ? v : dce_pkg::LEVEL_ZERO;
               rsp_status_in = status_ff;
               rsp_fading_in = fade_ff;
               rsp_prog_in   = prog_ff;
               rsp_cue_in    = cur_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_ff        <= '0;
         ticks_ff      <= dce_pkg::TICKS_RESET;
         undo_valid_ff <= 1'b0;
         cur_ff        <= '0;
         target_ff     <= '0;
         fade_ff       <= 1'b0;
         elapsed_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         ticks_ff      <= ticks_in;
         undo_valid_ff <= undo_valid_in;
         cur_ff        <= cur_in;
         target_ff     <= target_in;
         fade_ff       <= fade_in;
         elapsed_ff    <= elapsed_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      ch_ff         <= ch_in;
      cue_ff        <= cue_in;
      status_ff     <= status_in;
      nv_ff         <= nv_in;
      pk0_ff        <= pk0_in;
      pk1_ff        <= pk1_in;
      two_ff        <= two_in;
      phase_ff      <= phase_in;
      pos_ff        <= pos_in;
      wpos_ff       <= wpos_in;
      fpos_ff       <= fpos_in;
      left_ff       <= left_in;
      pend_ff       <= pend_in;
      aprod_ff      <= aprod_in;
      rem_ff        <= rem_in;
      dsr_ff        <= dsr_in;
      q_ff          <= q_in;
      cnt_ff        <= cnt_in;
      cap_ff        <= cap_in;
      prog_ff       <= prog_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_fading_ff <= rsp_fading_in;
      rsp_prog_ff   <= rsp_prog_in;
      rsp_cue_ff    <= rsp_cue_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_value      = rsp_value_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_fading     = rsp_fading_ff;
   assign rsp_progress   = rsp_prog_ff;
   assign rsp_active_cue = rsp_cue_ff;

   `DCE_ASSERT_IMPL(a_no_write_idle, state_ff == S_IDLE, !mem_we, "RAM written while idle")
   `DCE_ASSERT_IMPL(a_elapsed_idle, !fade_ff, elapsed_ff == '0, "elapsed count left over")
   `DCE_ASSERT_IMPL(a_busy_fading, rsp_valid_ff && (rsp_status_ff == dce_pkg::ST_BUSY), rsp_fading_ff, "busy word without fade")
   `DCE_ASSERT_IMPL(a_cue_range, 1'b1, int'(cur_ff) < dce_pkg::CUES, "active cue out of range")
   `DCE_ASSERT_RST(a_word_from_out, $rose(rsp_valid_ff) |-> $past(state_ff) == S_OUT, "result word not from output state")

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Testbench of the DMX cue crossfade editor: directed and random commands, scoreboarded.
module testbench;

   localparam int RUN_LIMIT = 20_000_000;

   typedef struct packed {
      dce_pkg::level_type  value;
      dce_pkg::status_type status;
      logic       fading;
      logic [dce_pkg::PROG_W-1:0] progress;
      logic [dce_pkg::CUE_W-1:0]  active_cue;
   } cue_word_type;

   class cue_scoreboard;
      dce_pkg::level_type live[dce_pkg::CHANNELS];
      dce_pkg::level_type undo_copy[dce_pkg::CHANNELS];
      dce_pkg::level_type cues[dce_pkg::CUES][dce_pkg::CHANNELS];
      bit        undo_ok;
      int unsigned cur_cue, next_cue, elapsed, ticks;
      bit        in_fade;
      cue_word_type expected_q[$];
      int        errors;

      function new();
         foreach (live[i]) begin
            live[i] = dce_pkg::LEVEL_ZERO;
            undo_copy[i] = dce_pkg::LEVEL_ZERO;
         end
         foreach (cues[c, i]) cues[c][i] = dce_pkg::LEVEL_ZERO;
         undo_ok = 0; cur_cue = 0; next_cue = 0; elapsed = 0;
         ticks = 32'(dce_pkg::TICKS_RESET); in_fade = 0; errors = 0;
      endfunction

      task report(string what);
         $display("mismatch at %0t: %s", $time, what);
         errors++;
      endtask

      function void snapshot();
         undo_copy = live;
         undo_ok = 1;
      endfunction

      function void advance_fade();
         int unsigned e;
         elapsed = (elapsed + 1) & 16'hFFFF;
         e = elapsed;
         if (e >= ticks || e == 0) begin
            cur_cue = next_cue;
            live = cues[cur_cue];
            in_fade = 0;
            elapsed = 0;
            return;
         end
         for (int i = 0; i < dce_pkg::CHANNELS; i++)
            live[i] = dce_pkg::level_type'((cues[cur_cue][i] * (ticks - e) +
                                            cues[next_cue][i] * e) / ticks);
      endfunction

      // Apply one accepted command and queue the word it must produce.
      function void note_command(dce_pkg::cmd_type cmd, int unsigned ch, int unsigned cue);
         dce_pkg::level_type v = live[ch];
         cue_word_type w;
         int unsigned prog;
         w.status = dce_pkg::ST_OK;
         if (in_fade && cmd != dce_pkg::CMD_TICK) w.status = dce_pkg::ST_BUSY;
         else case (cmd)
            dce_pkg::CMD_UP16: begin
               snapshot();
               live[ch] = (v < dce_pkg::LEVEL_FULL - dce_pkg::LEVEL_STEP) ?
                          v + dce_pkg::LEVEL_STEP : dce_pkg::LEVEL_FULL;
            end
            dce_pkg::CMD_UP1:
               if (v < dce_pkg::LEVEL_FULL) begin snapshot(); live[ch] = v + 1'b1; end
            dce_pkg::CMD_DOWN16: begin
               snapshot();
               live[ch] = (v == dce_pkg::LEVEL_FULL) ? dce_pkg::LEVEL_COARSE :
                          (v > dce_pkg::LEVEL_STEP) ? v - dce_pkg::LEVEL_STEP :
                          dce_pkg::LEVEL_ZERO;
            end
            dce_pkg::CMD_DOWN1:
               if (v > 0) begin snapshot(); live[ch] = v - 1'b1; end
            dce_pkg::CMD_TOGGLE: begin
               snapshot();
               live[ch] = (v < dce_pkg::LEVEL_HALF) ? dce_pkg::LEVEL_FULL : dce_pkg::LEVEL_ZERO;
            end
            dce_pkg::CMD_INSERT: begin
               snapshot();
               for (int n = dce_pkg::CHANNELS - 1; n > int'(ch); n--) live[n] = live[n-1];
            end
            dce_pkg::CMD_DELETE: begin
               snapshot();
               for (int n = int'(ch); n + 1 < dce_pkg::CHANNELS; n++) live[n] = live[n+1];
            end
            dce_pkg::CMD_BLACKOUT: begin
               snapshot();
               foreach (live[i]) live[i] = dce_pkg::LEVEL_ZERO;
            end
            dce_pkg::CMD_FULL: begin
               snapshot();
               foreach (live[i]) live[i] = dce_pkg::LEVEL_FULL;
            end
            dce_pkg::CMD_UNDO: if (undo_ok) begin live = undo_copy; undo_ok = 0; end
            dce_pkg::CMD_SAVE: cues[cur_cue] = live;
            dce_pkg::CMD_GOTO: begin
               if (cue >= dce_pkg::CUES) w.status = dce_pkg::ST_RANGE;
               else begin
                  undo_ok = 0;
                  cues[cur_cue] = live;
                  if (ticks == 0) begin
                     cur_cue = cue;
                     live = cues[cue];
                  end else begin
                     next_cue = cue;
                     in_fade = 1;
                     elapsed = 0;
                  end
               end
            end
            dce_pkg::CMD_TICK: if (in_fade) advance_fade();
            default: ;
         endcase
         prog = 0;
         if (in_fade) begin
            prog = dce_pkg::PROG_CAP;
            if (ticks != 0) begin
               prog = elapsed * dce_pkg::PROG_SCALE / ticks;
               if (prog > dce_pkg::PROG_CAP) prog = dce_pkg::PROG_CAP;
            end
         end
         w.value = live[ch];
         w.fading = in_fade;
         w.progress = dce_pkg::PROG_W'(prog);
         w.active_cue = dce_pkg::CUE_W'(cur_cue);
         expected_q.push_back(w);
      endfunction

      task check_word(cue_word_type got);
         cue_word_type exp;
         if (expected_q.size() == 0) begin
            report("result word with nothing expected");
            return;
         end
         exp = expected_q.pop_front();
         if (got.value != exp.value)
            report($sformatf("value %0d, expected %0d", got.value, exp.value));
         if (got.status != exp.status)
            report($sformatf("status %0d, expected %0d", got.status, exp.status));
         if (got.fading != exp.fading)
            report($sformatf("fading %0d, expected %0d", got.fading, exp.fading));
         if (got.progress != exp.progress)
            report($sformatf("progress %0d, expected %0d", got.progress, exp.progress));
         if (got.active_cue != exp.active_cue)
            report($sformatf("active cue %0d, expected %0d", got.active_cue, exp.active_cue));
      endtask
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic [dce_pkg::CMD_W-1:0]   req_cmd = '0;
   logic [dce_pkg::CH_IN_W-1:0] req_channel = '0;
   logic [dce_pkg::CUE_W-1:0]   req_cue = '0;
   logic rsp_valid;
   logic rsp_stall = 0;
   dce_pkg::level_type  rsp_value;
   dce_pkg::status_type rsp_status;
   logic rsp_fading;
   logic [dce_pkg::PROG_W-1:0] rsp_progress;
   logic [dce_pkg::CUE_W-1:0]  rsp_active_cue;
   logic csr_write = 0;
   logic [dce_pkg::TICKS_W-1:0] csr_wdata = '0;

   cue_scoreboard board = new();
   bit calm = 0;
   int stall_left = 0;
   int cycles = 0;

   dmx_cue_crossfade_editor u_top (
      .clock, .reset,
      .req_valid, .req_stall, .req_cmd, .req_channel, .req_cue,
      .rsp_valid, .rsp_stall, .rsp_value, .rsp_status, .rsp_fading,
      .rsp_progress, .rsp_active_cue,
      .csr_write, .csr_wdata
   );

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > RUN_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   function automatic int pick_gap();
      int r = $urandom_range(0, 99);
      if (calm || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // Take result words; stall in bursts.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_word({rsp_value, rsp_status, rsp_fading, rsp_progress, rsp_active_cue});
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= 1;
      end else begin
         stall_left <= pick_gap();
         rsp_stall <= 0;
      end
   end

   task automatic send(dce_pkg::cmd_type cmd, int unsigned ch, int unsigned cue);
      int gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_cmd <= cmd;
      req_channel <= dce_pkg::CH_IN_W'(ch);
      req_cue <= dce_pkg::CUE_W'(cue);
      do @(posedge clock); while (!(req_valid && !req_stall));
      board.note_command(cmd, ch, cue);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (board.expected_q.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   task automatic write_ticks(int unsigned v);
      drain();
      csr_write <= 1;
      csr_wdata <= dce_pkg::TICKS_W'(v);
      @(posedge clock);
      csr_write <= 0;
      board.ticks = v;
   endtask

   function automatic int unsigned pick_channel();
      int r = $urandom_range(0, 3);
      if (r < 2) return $urandom_range(0, 3);
      if (r == 2) return $urandom_range(dce_pkg::CHANNELS - 4, dce_pkg::CHANNELS - 1);
      return $urandom_range(0, dce_pkg::CHANNELS - 1);
   endfunction

   task automatic random_command();
      int r = $urandom_range(0, 99);
      int unsigned cue = ($urandom_range(0, 99) < 85) ?
                         $urandom_range(0, dce_pkg::CUES - 1) :
                         $urandom_range(dce_pkg::CUES, 15);
      if (board.in_fade) begin
         // mostly advance the fade; the rest are random commands, mostly bouncing off as busy
         if (r < 80) send(dce_pkg::CMD_TICK, pick_channel(), cue);
         else send(dce_pkg::cmd_type'($urandom_range(0, 15)), pick_channel(), cue);
      end else if (r < 10) send(dce_pkg::CMD_GOTO, pick_channel(), cue);
      else if (r < 15) send(dce_pkg::CMD_SAVE, pick_channel(), cue);
      else if (r < 21) send(dce_pkg::CMD_UNDO, pick_channel(), cue);
      else if (r < 24) send(dce_pkg::CMD_BLACKOUT, pick_channel(), cue);
      else if (r < 27) send(dce_pkg::CMD_FULL, pick_channel(), cue);
      else if (r < 29) send(dce_pkg::cmd_type'($urandom_range(14, 15)), pick_channel(), cue);
      else if (r < 33) send(dce_pkg::CMD_TICK, pick_channel(), cue);
      else send(dce_pkg::cmd_type'($urandom_range(dce_pkg::CMD_READ, dce_pkg::CMD_DELETE)),
                pick_channel(), cue);
   endtask

   initial begin
      int unsigned phase_ticks[6] = '{65535, 2, 0, 1, 3, 10};
      int phase_items[6] = '{40, 130, 130, 100, 130, 70};
      repeat (5) @(posedge clock);
      reset <= 0;

      send(dce_pkg::CMD_READ, 5, 0);
      send(dce_pkg::CMD_UP16, 5, 0);
      send(dce_pkg::CMD_UP1, 5, 0);
      send(dce_pkg::CMD_DOWN16, 5, 0);
      send(dce_pkg::CMD_DOWN1, 5, 0);
      send(dce_pkg::CMD_FULL, 0, 0);
      send(dce_pkg::CMD_DOWN16, 5, 0);
      send(dce_pkg::CMD_UP1, 511, 0);
      send(dce_pkg::CMD_TOGGLE, 5, 0);
      send(dce_pkg::CMD_TOGGLE, 5, 0);
      send(dce_pkg::CMD_INSERT, 3, 0);
      send(dce_pkg::CMD_DELETE, 3, 0);
      send(dce_pkg::CMD_UNDO, 3, 0);
      send(dce_pkg::CMD_UNDO, 3, 0);
      send(dce_pkg::CMD_BLACKOUT, 511, 0);
      send(dce_pkg::CMD_SAVE, 0, 0);
      send(dce_pkg::cmd_type'(14), 0, 0);
      send(dce_pkg::cmd_type'(15), 0, 0);
      send(dce_pkg::CMD_UP16, 0, 0);
      send(dce_pkg::CMD_GOTO, 0, 15);
      send(dce_pkg::CMD_GOTO, 0, 2);
      send(dce_pkg::CMD_READ, 0, 0);
      repeat (3) send(dce_pkg::CMD_TICK, 0, 0);

      for (int p = 0; p < 6; p++) begin
         write_ticks(phase_ticks[p]);
         calm = (p == 3);
         for (int k = 0; k < phase_items[p]; k++) random_command();
      end
      calm = 0;

      drain();
      if (board.errors == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end
endmodule
